// ----- sv/rgtp_pkg.sv -----
// Shared types, constants and helper functions for the grid test pattern core.
// No dependencies; every other file imports this package.
`default_nettype none
package rgtp_pkg;

  // Coordinate width of the pixel channel
  localparam int COORD_BITS = 12;
  // Fixed widths of the configuration fields
  localparam int SCREEN_BITS = 12;
  localparam int COUNT_BITS  = 8;
  localparam int STEP_BITS   = 8;
  localparam int BPP_BITS    = 6;
  localparam int CFG_DATA_W  = 48;
  localparam int CFG_IDX_W   = 3;

  // Divider width covers both the pixel coordinate and the screen size
  localparam int DIV_W = (COORD_BITS > SCREEN_BITS) ? COORD_BITS : SCREEN_BITS;

  // Register reset values
  localparam logic [SCREEN_BITS-1:0] RST_SCREEN_W = SCREEN_BITS'(1024);
  localparam logic [SCREEN_BITS-1:0] RST_SCREEN_H = SCREEN_BITS'(768);
  localparam logic [COUNT_BITS-1:0]  RST_COUNT    = COUNT_BITS'(1);
  localparam logic [BPP_BITS-1:0]    RST_BPP      = BPP_BITS'(8);
  localparam logic [SCREEN_BITS-1:0] RST_TILE_W   = SCREEN_BITS'(1024 / 1);
  localparam logic [SCREEN_BITS-1:0] RST_TILE_H   = SCREEN_BITS'(768 / 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIRECT_MODE    = 3'd0,
    REG_FIRST_COLOUR   = 3'd1,
    REG_RECT_COUNT     = 3'd2,
    REG_COLOUR_STEP    = 3'd3,
    REG_BITS_PER_PIXEL = 3'd4,
    REG_SCREEN_WIDTH   = 3'd5,
    REG_SCREEN_HEIGHT  = 3'd6,
    REG_CHANNEL_LAYOUT = 3'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    CFG_IDLE,
    CFG_LOAD,
    CFG_DIVIDE
  } cfg_state_t;

  // Partial remainder and shifting dividend/quotient of a restoring divider
  typedef struct packed {
    logic [DIV_W-1:0] rem;
    logic [DIV_W-1:0] quo;
  } div_t;

  // One restoring division step: shift in the next dividend bit, subtract if it fits
  function automatic div_t div_step(div_t s, logic [DIV_W-1:0] d);
    logic [DIV_W:0] trial;
    div_t           r;
    trial = {s.rem, s.quo[DIV_W-1]};
    r.quo = {s.quo[DIV_W-2:0], 1'b0};
    r.rem = trial[DIV_W-1:0];
    if (trial >= {1'b0, d}) begin
      r.rem    = DIV_W'(trial - {1'b0, d});
      r.quo[0] = 1'b1;
    end
    return r;
  endfunction

  // Mask of the low bits; zero bits gives 0, 32 or more gives all ones
  function automatic logic [31:0] low_mask32(logic [7:0] bits);
    logic [31:0] m;
    if (bits == 8'd0) begin
      m = 32'd0;
    end else if (bits >= 8'd32) begin
      m = 32'hFFFF_FFFF;
    end else begin
      m = (32'd1 << bits[4:0]) - 32'd1;
    end
    return m;
  endfunction

  // Extract one colour field, add the column offset, wrap and repack
  function automatic logic [31:0] chan_value(logic [31:0] first, logic [7:0] pos,
                                             logic [7:0] size, logic [15:0] cs);
    logic [31:0] mask;
    logic [31:0] field;
    logic [31:0] sum;
    logic [31:0] res;
    mask  = low_mask32(size);
    field = (first >> pos[4:0]) & mask;
    sum   = (field + 32'(cs)) & mask;
    res   = (pos >= 8'd32) ? 32'd0 : (sum << pos[4:0]);
    return res;
  endfunction

endpackage
`default_nettype wire

// ----- sv/rgtp_if.sv -----
// Valid/ready channel interfaces of the grid test pattern core: pixel
// requests, colour results and configuration writes. Depends on rgtp_pkg.
`default_nettype none
interface rgtp_pix_if import rgtp_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] pixel_x;
  logic [COORD_BITS-1:0] pixel_y;
  modport source (output valid, output pixel_x, output pixel_y, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface rgtp_col_if import rgtp_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [31:0] pixel_colour;
  logic        inside_grid;
  modport source (output valid, output pixel_colour, output inside_grid, input ready);
  modport sink   (input valid, input pixel_colour, input inside_grid, output ready);
endinterface

interface rgtp_cfg_if import rgtp_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ----- sv/rectangle_grid_test_pattern_core.sv -----
// Grid test pattern core: maps a pixel coordinate to a tile colour.
// Depends on rgtp_pkg and the channel interfaces in rgtp_if.sv.
//
// The core takes one pixel request per clock while in_ch.ready is high. The
// column and row are found by a pipelined restoring divider, one quotient bit
// per stage, which makes up most of the pipeline; three more stages hold the
// range check and tile index multiply, the colour step multiply, and the final
// add/mask or RGB field pack. Each stage carries its own valid bit and stalls
// only when the stage after it is full and cannot move on, so bubbles collapse
// and requests keep filling empty stages while a finished result waits for
// out_ch.ready. Writing rect_count, screen_width or screen_height starts a tile
// size division; during it cfg_ch.ready and in_ch.ready are low. Other
// registers are taken without a division.
`default_nettype none
module rectangle_grid_test_pattern_core import rgtp_pkg::*; (
  input  wire          clk,
  input  wire          rst_n,
  rgtp_pix_if.sink     in_ch,
  rgtp_col_if.source   out_ch,
  rgtp_cfg_if.sink     cfg_ch
);

  localparam int ST_A = DIV_W + 1;   // range check, row * count
  localparam int ST_B = DIV_W + 2;   // index * step, column * step
  localparam int ST_C = DIV_W + 3;   // colour assembly, output register
  localparam int NST  = DIV_W + 4;
  localparam int CNT_W = $clog2(DIV_W);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic                   direct_mode_r;
  logic [31:0]            first_colour_r;
  logic [COUNT_BITS-1:0]  rect_count_r;
  logic [STEP_BITS-1:0]   colour_step_r;
  logic [BPP_BITS-1:0]    bpp_r;
  logic [SCREEN_BITS-1:0] screen_w_r;
  logic [SCREEN_BITS-1:0] screen_h_r;
  logic [CFG_DATA_W-1:0]  layout_r;

  // Tile size, derived from the registers above
  logic [SCREEN_BITS-1:0] tile_w_r;
  logic [SCREEN_BITS-1:0] tile_h_r;

  cfg_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] div_cnt_r;
  div_t             tw_div_r, th_div_r;
  div_t             tw_step, th_step;
  logic             cfg_idle;
  logic             div_load;
  logic             div_run;
  logic             div_last;
  logic             cfg_acc;
  logic             size_write;
  cfg_reg_t         cfg_reg;

  assign cfg_reg  = cfg_reg_t'(cfg_ch.index);
  assign cfg_acc  = cfg_ch.valid && cfg_idle;
  assign div_last = div_run && (div_cnt_r == CNT_W'(DIV_W - 1));

  always_comb begin
    unique case (cfg_reg)
      REG_RECT_COUNT, REG_SCREEN_WIDTH, REG_SCREEN_HEIGHT: size_write = 1'b1;
      default:                                             size_write = 1'b0;
    endcase
  end

  // Next state of the tile size sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      CFG_IDLE:   if (cfg_acc && size_write) state_nxt = CFG_LOAD;
      CFG_LOAD:   state_nxt = CFG_DIVIDE;
      CFG_DIVIDE: if (div_last) state_nxt = CFG_IDLE;
      default:    state_nxt = CFG_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    cfg_idle = 1'b0;
    div_load = 1'b0;
    div_run  = 1'b0;
    unique case (state_r)
      CFG_IDLE:   cfg_idle = 1'b1;
      CFG_LOAD:   div_load = 1'b1;
      CFG_DIVIDE: div_run  = 1'b1;
      default:    cfg_idle = 1'b0;
    endcase
  end

  assign cfg_ch.ready = cfg_idle;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= CFG_IDLE;
      div_cnt_r      <= '0;
      direct_mode_r  <= 1'b0;
      first_colour_r <= 32'd0;
      rect_count_r   <= RST_COUNT;
      colour_step_r  <= '0;
      bpp_r          <= RST_BPP;
      screen_w_r     <= RST_SCREEN_W;
      screen_h_r     <= RST_SCREEN_H;
      layout_r       <= '0;
      tile_w_r       <= RST_TILE_W;
      tile_h_r       <= RST_TILE_H;
    end else begin
      state_r <= state_nxt;
      if (cfg_acc) begin
        unique case (cfg_reg)
          REG_DIRECT_MODE:    direct_mode_r  <= cfg_ch.data[0];
          REG_FIRST_COLOUR:   first_colour_r <= cfg_ch.data[31:0];
          REG_RECT_COUNT:     rect_count_r   <= cfg_ch.data[COUNT_BITS-1:0];
          REG_COLOUR_STEP:    colour_step_r  <= cfg_ch.data[STEP_BITS-1:0];
          REG_BITS_PER_PIXEL: bpp_r          <= cfg_ch.data[BPP_BITS-1:0];
          REG_SCREEN_WIDTH:   screen_w_r     <= cfg_ch.data[SCREEN_BITS-1:0];
          REG_SCREEN_HEIGHT:  screen_h_r     <= cfg_ch.data[SCREEN_BITS-1:0];
          REG_CHANNEL_LAYOUT: layout_r       <= cfg_ch.data;
          default:            layout_r       <= layout_r;
        endcase
      end
      // Count division steps; latch the tile size on the last one
      if (div_load) begin
        div_cnt_r <= '0;
      end else if (div_run) begin
        div_cnt_r <= div_cnt_r + CNT_W'(1);
      end
      if (div_last) begin
        tile_w_r <= tw_step.quo[SCREEN_BITS-1:0];
        tile_h_r <= th_step.quo[SCREEN_BITS-1:0];
      end
    end
  end

  // Shared-width divider iterating screen size / rect_count, one bit per cycle
  assign tw_step = div_step(tw_div_r, DIV_W'(rect_count_r));
  assign th_step = div_step(th_div_r, DIV_W'(rect_count_r));

  always_ff @(posedge clk) begin
    if (div_load) begin
      tw_div_r <= '{rem: '0, quo: DIV_W'(screen_w_r)};
      th_div_r <= '{rem: '0, quo: DIV_W'(screen_h_r)};
    end else if (div_run) begin
      tw_div_r <= tw_step;
      th_div_r <= th_step;
    end
  end

  // ---------------------------------------------------------------------------
  // Pixel pipeline
  // ---------------------------------------------------------------------------
  logic [NST-1:0] v_r;
  logic [NST:0]   rdy;
  logic           in_acc;

  // A stage takes a new request when it is empty or its content moves on
  assign rdy[NST] = out_ch.ready;
  for (genvar i = 0; i < NST; i++) begin : g_rdy
    assign rdy[i] = ~v_r[i] | rdy[i+1];
  end

  assign in_ch.ready = rdy[0] && cfg_idle;
  assign in_acc      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) v_r[0] <= in_acc;
      for (int i = 1; i < NST; i++) begin
        if (rdy[i]) v_r[i] <= v_r[i-1];
      end
    end
  end

  // Divider stages: column = x / tile_w, row = y / tile_h
  div_t dx_r [0:DIV_W];
  div_t dy_r [0:DIV_W];

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      dx_r[0] <= '{rem: '0, quo: DIV_W'(in_ch.pixel_x)};
      dy_r[0] <= '{rem: '0, quo: DIV_W'(in_ch.pixel_y)};
    end
  end

  for (genvar s = 1; s <= DIV_W; s++) begin : g_div
    always_ff @(posedge clk) begin
      if (rdy[s]) begin
        dx_r[s] <= div_step(dx_r[s-1], DIV_W'(tile_w_r));
        dy_r[s] <= div_step(dy_r[s-1], DIV_W'(tile_h_r));
      end
    end
  end

  // Stage A: range check and row * count
  logic [DIV_W-1:0]      col_q, row_q;
  logic                  a_inside;
  logic                  a_inside_r;
  logic [15:0]           a_rc_r;
  logic [COUNT_BITS-1:0] a_col_r;

  assign col_q    = dx_r[DIV_W].quo;
  assign row_q    = dy_r[DIV_W].quo;
  // Zero tile count or a tile narrower than one pixel leaves everything outside
  assign a_inside = (rect_count_r != '0) && (tile_w_r != '0) && (tile_h_r != '0) &&
                    (col_q < DIV_W'(rect_count_r)) && (row_q < DIV_W'(rect_count_r));

  always_ff @(posedge clk) begin
    if (rdy[ST_A]) begin
      a_inside_r <= a_inside;
      a_rc_r     <= 16'(row_q[COUNT_BITS-1:0]) * 16'(rect_count_r);
      a_col_r    <= col_q[COUNT_BITS-1:0];
    end
  end

  // Stage B: tile index * step and column * step
  logic [15:0] b_idx;
  logic        b_inside_r;
  logic [23:0] b_prod_r;
  logic [15:0] b_cs_r;

  assign b_idx = a_rc_r + 16'(a_col_r);

  always_ff @(posedge clk) begin
    if (rdy[ST_B]) begin
      b_inside_r <= a_inside_r;
      b_prod_r   <= 24'(b_idx) * 24'(colour_step_r);
      b_cs_r     <= 16'(a_col_r) * 16'(colour_step_r);
    end
  end

  // Stage C: indexed wrap or RGB repack; outside pixels read as colour 0
  logic [31:0] c_indexed;
  logic [31:0] c_direct;
  logic [31:0] c_colour;
  logic [31:0] c_colour_r;
  logic        c_inside_r;

  assign c_indexed = (first_colour_r + 32'(b_prod_r)) & low_mask32(8'(bpp_r));
  // Overlapping channels simply OR together
  assign c_direct  = chan_value(first_colour_r, layout_r[7:0],   layout_r[15:8],  b_cs_r) |
                     chan_value(first_colour_r, layout_r[23:16], layout_r[31:24], b_cs_r) |
                     chan_value(first_colour_r, layout_r[39:32], layout_r[47:40], b_cs_r);
  assign c_colour  = !b_inside_r   ? 32'd0 :
                     direct_mode_r ? c_direct : c_indexed;

  always_ff @(posedge clk) begin
    if (rdy[ST_C]) begin
      c_inside_r <= b_inside_r;
      c_colour_r <= c_colour;
    end
  end

  assign out_ch.valid        = v_r[ST_C];
  assign out_ch.pixel_colour = c_colour_r;
  assign out_ch.inside_grid  = c_inside_r;

endmodule
`default_nettype wire
